FILE: hdl/sst_pkg.sv
// Shared types and byte codes for the shell-style tokenizer.
// No dependencies; imported by every module of the block.
package sst_pkg;

    // Lexer position within the text
    typedef enum logic [2:0] {
        LX_IDLE = 3'd0,
        LX_BARE = 3'd1,
        LX_SQ   = 3'd2,
        LX_DQ   = 3'd3,
        LX_ESC  = 3'd4,
        LX_QESC = 3'd5
    } t_lex_state;

    // Result word kinds
    typedef enum logic [2:0] {
        KIND_BYTE      = 3'd0,
        KIND_END       = 3'd1,
        KIND_DONE      = 3'd2,
        KIND_QUOTE_ERR = 3'd3,
        KIND_ESC_ERR   = 3'd4
    } t_kind;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    localparam int TOKEN_COUNT_W = 16;

    // One result word
    typedef struct packed {
        t_kind                    kind;
        logic [7:0]               data;
        logic                     text_done;
        logic [TOKEN_COUNT_W-1:0] token_count;
    } t_result;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

endpackage

FILE: hdl/sst_lexer.sv
// Next-state and result logic of the tokenizer for one text byte.
// Purely combinational; depends on sst_pkg.
module sst_lexer
    import sst_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  t_lex_state             i_state,
    input  logic [COUNT_WIDTH-1:0] i_count,
    input  logic [7:0]             i_ch,
    output t_lex_state             o_state,
    output logic [COUNT_WIDTH-1:0] o_count,
    output logic                   o_push,
    output t_result                o_result
);

    logic [COUNT_WIDTH-1:0] bumped;
    logic [COUNT_WIDTH-1:0] res_cnt;
    logic [COUNT_WIDTH+TOKEN_COUNT_W-1:0] cnt_ext;
    logic                   nul;
    logic                   spc;

    assign bumped  = (i_count == {COUNT_WIDTH{1'b1}}) ? i_count
                                                      : i_count + COUNT_WIDTH'(1);
    assign nul     = (i_ch == CH_NUL);
    assign spc     = is_space(i_ch);

    always_comb begin
        o_state          = i_state;
        o_count          = i_count;
        o_push           = 1'b0;
        res_cnt          = i_count;
        o_result.kind    = KIND_BYTE;
        o_result.data    = 8'h00;
        o_result.text_done = 1'b0;

        unique case (i_state)
            LX_BARE: begin
                if (nul) begin
                    res_cnt = bumped;
                    o_push = 1'b1;
                    o_result.kind = KIND_DONE;
                    o_result.text_done = 1'b1;
                    o_state = LX_IDLE;
                    o_count = '0;
                end else if (spc) begin
                    res_cnt = bumped;
                    o_count = bumped;
                    o_push = 1'b1;
                    o_result.kind = KIND_END;
                    o_state = LX_IDLE;
                end else if (i_ch == CH_SQUOTE) begin
                    o_state = LX_SQ;
                end else if (i_ch == CH_DQUOTE) begin
                    o_state = LX_DQ;
                end else if (i_ch == CH_BSLASH) begin
                    o_state = LX_ESC;
                end else begin
                    o_push = 1'b1;
                    o_result.data = i_ch;
                end
            end
            LX_SQ: begin
                if (nul) begin
                    o_push = 1'b1;
                    o_result.kind = KIND_QUOTE_ERR;
                    o_result.text_done = 1'b1;
                    o_state = LX_IDLE;
                    o_count = '0;
                end else if (i_ch == CH_SQUOTE) begin
                    o_state = LX_BARE;
                end else begin
                    o_push = 1'b1;
                    o_result.data = i_ch;
                end
            end
            LX_DQ: begin
                if (nul) begin
                    o_push = 1'b1;
                    o_result.kind = KIND_QUOTE_ERR;
                    o_result.text_done = 1'b1;
                    o_state = LX_IDLE;
                    o_count = '0;
                end else if (i_ch == CH_DQUOTE) begin
                    o_state = LX_BARE;
                end else if (i_ch == CH_BSLASH) begin
                    o_state = LX_QESC;
                end else begin
                    o_push = 1'b1;
                    o_result.data = i_ch;
                end
            end
            LX_ESC, LX_QESC: begin
                o_push = 1'b1;
                if (nul) begin
                    o_result.kind = KIND_ESC_ERR;
                    o_result.text_done = 1'b1;
                    o_state = LX_IDLE;
                    o_count = '0;
                end else begin
                    o_result.data = i_ch;
                    o_state = (i_state == LX_ESC) ? LX_BARE : LX_DQ;
                end
            end
            default: begin
                // between words; stray codes land here too
                o_state = LX_IDLE;
                if (nul) begin
                    o_push = 1'b1;
                    o_result.kind = KIND_DONE;
                    o_result.text_done = 1'b1;
                    o_count = '0;
                end else if (spc) begin
                    o_state = LX_IDLE;
                end else if (i_ch == CH_SQUOTE) begin
                    o_state = LX_SQ;
                end else if (i_ch == CH_DQUOTE) begin
                    o_state = LX_DQ;
                end else if (i_ch == CH_BSLASH) begin
                    o_state = LX_ESC;
                end else begin
                    o_state = LX_BARE;
                    o_push = 1'b1;
                    o_result.data = i_ch;
                end
            end
        endcase

        cnt_ext = {{TOKEN_COUNT_W{1'b0}}, res_cnt};
        o_result.token_count = cnt_ext[TOKEN_COUNT_W-1:0];
    end

endmodule

FILE: hdl/sst_out_buf.sv
// Result register plus one skid entry for the output channel.
// Depends on sst_pkg for the result word type.
module sst_out_buf
    import sst_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    input  logic    i_out_stall,
    output logic    o_out_valid,
    output t_result o_result,
    output logic    o_full
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    out_take;

    assign out_take = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_take) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (out_take) begin
            r_out <= r_skid_valid ? r_skid : i_result;
        end else if (i_push) begin
            if (r_out_valid) begin
                r_skid <= i_result;
            end else begin
                r_out <= i_result;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;
    assign o_full      = r_skid_valid;

endmodule

FILE: hdl/shell_style_tokenizer_unit.sv
// Shell-style tokenizer, top level: one text byte per word in, token bytes out.
// Depends on sst_pkg, sst_lexer and sst_out_buf.
//
// The block takes one text byte per cycle while o_in_stall is low (byte 0
// ends the text) and splits it into words on space, tab, CR and LF, honoring
// single quotes, double quotes with backslash escapes, and bare backslash
// escapes. Each word byte comes out at once as a kind 0 word; a kind 1 word
// marks a word closed by whitespace, and the text ends with one word of kind
// 2 (done), 3 (unclosed quote) or 4 (dangling backslash), carrying text_done.
// Syntax bytes and separating whitespace give no kind 0 word. token_count is
// the saturating count of words closed so far in this text (low 16 bits
// shown); it and the lexer state clear at every text end. Throughput is one
// byte per cycle while o_in_stall is low: the lexer state update is a small
// decode on the incoming byte and the state register, feeding a result
// register. A skid entry behind the result register lets a byte be accepted
// while a result waits; o_in_stall rises only when both are full.
module shell_style_tokenizer_unit
    import sst_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input byte channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_ch,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_data,
    output logic        o_text_done,
    output logic [15:0] o_token_count
);

    t_lex_state             r_state;
    t_lex_state             n_state;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] n_count;
    logic                   push_res;
    t_result                lex_res;
    t_result                out_res;
    logic                   in_accept;
    logic                   buf_full;

    assign o_in_stall = buf_full;
    assign in_accept  = i_in_valid && !buf_full;

    sst_lexer #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_lexer (
        .i_state  (r_state),
        .i_count  (r_count),
        .i_ch     (i_ch),
        .o_state  (n_state),
        .o_count  (n_count),
        .o_push   (push_res),
        .o_result (lex_res)
    );

    // lexer state advances once per accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LX_IDLE;
            r_count <= '0;
        end else if (in_accept) begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    sst_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (in_accept && push_res),
        .i_result    (lex_res),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_result    (out_res),
        .o_full      (buf_full)
    );

    assign o_kind        = out_res.kind;
    assign o_data        = out_res.data;
    assign o_text_done   = out_res.text_done;
    assign o_token_count = out_res.token_count;

    // a full skid entry implies a waiting result word
    a_skid_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        buf_full |-> o_out_valid)
        else $error("skid entry held without a valid result word");

    // text end always leaves the lexer idle with a cleared count
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_ch == CH_NUL) |=> (r_state == LX_IDLE && r_count == '0))
        else $error("lexer not reset after end of text");

    // only word bytes carry data
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind != KIND_BYTE) |-> (o_data == 8'h00))
        else $error("nonzero data on a non-byte result");

    // text_done marks exactly the terminating kinds
    a_done_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_text_done == (o_kind == KIND_DONE ||
                                         o_kind == KIND_QUOTE_ERR ||
                                         o_kind == KIND_ESC_ERR)))
        else $error("text_done does not match result kind");

endmodule
